/* hdl/adrd_pkg.sv */
// Shared types and constants for the ADPCM audio record decoder.
// No dependencies.
`timescale 1ns / 1ps
package adrd_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 65535;
  localparam int unsigned HEADER_BYTES    = 80;
  localparam int unsigned COEF_WORDS      = 32;
  localparam int unsigned CMD_DEPTH       = 2;

  localparam logic [1:0] CH_LEFT  = 2'd0;
  localparam logic [1:0] CH_RIGHT = 2'd1;
  localparam logic [1:0] CH_BOTH  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic [1:0]         channel;
    logic [15:0]        sample_index;
    logic               last_of_item;
    logic               record_done;
  } out_t;

  // One sample to decode
  typedef struct packed {
    logic [3:0]  nib;
    logic        side;
    logic [2:0]  pred;
    logic [3:0]  scale;
    logic        load_hist;
    logic [1:0]  channel;
    logic [15:0] index;
    logic        last;
    logic        done;
  } cmd_t;

  // Header word write: words 0..31 are coefficients, 32..35 start history
  typedef struct packed {
    logic        we;
    logic [5:0]  addr;
    logic [15:0] data;
  } wr_t;

endpackage

/* hdl/adpcm_audio_record_decoder_top.sv */
// Channel  | ports                         | transfer when
// in       | in_push, in_full, in_data     | in_push && !in_full
// out      | out_pop, out_empty, out_data  | out_pop && !out_empty
//
// A data byte yields up to two samples; each sample passes through the
// back datapath steps (two coefficient memory reads, two multiplies, sum, round).
// Header bytes wait until the back part has drained, so coefficients change
// only when no sample is in flight. Reset is synchronous, active low.
// The output register holds one result; the back stalls in rounding while it is full and not popped.
// Depends on adrd_pkg, adrd_front, adrd_fifo, adrd_back.
`timescale 1ns / 1ps
module adpcm_audio_record_decoder_top #(
  parameter int unsigned MAX_SAMPLES = adrd_pkg::MAX_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  adrd_pkg::in_t  in_data,
  output logic           in_full,
  output adrd_pkg::out_t out_data,
  output logic           out_empty,
  input  logic           out_pop
);
  import adrd_pkg::*;

  cmd_t q_wdata, q_rdata;
  logic q_push, q_full, q_empty, q_pop, back_idle;
  wr_t  wr;

  adrd_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst_n, .in_push, .in_data, .in_full,
    .q_wdata, .q_push, .q_full, .q_empty, .back_idle, .wr
  );

  adrd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  adrd_back u_back (
    .clk, .rst_n, .wr, .q_rdata, .q_empty, .q_pop, .back_idle,
    .out_data, .out_empty, .out_pop
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("command queue overflow");

  a_hdr_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> (back_idle && q_empty)) else $error("header write while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result after reset");
endmodule

/* hdl/adrd_fifo.sv */
// Short command queue between front and back.
// Depends on adrd_pkg.
`timescale 1ns / 1ps
module adrd_fifo #(
  parameter int unsigned DEPTH = adrd_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  adrd_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output adrd_pkg::cmd_t rdata,
  output logic          empty
);
  import adrd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        mem_r[wp_r] <= wdata;
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop && !empty)
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

/* hdl/adrd_front.sv */
// Front: takes record bytes, parses the header and turns data nibbles into commands.
// Depends on adrd_pkg.
`timescale 1ns / 1ps
module adrd_front #(
  parameter int unsigned MAX_SAMPLES = adrd_pkg::MAX_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  adrd_pkg::in_t  in_data,
  output logic           in_full,
  output adrd_pkg::cmd_t q_wdata,
  output logic           q_push,
  input  logic           q_full,
  input  logic           q_empty,
  input  logic           back_idle,
  output adrd_pkg::wr_t  wr
);
  import adrd_pkg::*;

  typedef enum logic [2:0] {P_IDLE, P_HEADER, P_LEFT, P_SKIP, P_RIGHT} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] bpos_r, bpos_nxt;
  logic [31:0] roff_r, roff_nxt;
  logic [31:0] craw_r, craw_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] done_r, done_nxt;
  logic [3:0]  ncnt_r, ncnt_nxt;
  logic [2:0]  pred_r, pred_nxt;
  logic [3:0]  scale_r, scale_nxt;
  logic        load_r, load_nxt;
  logic [7:0]  hi_r, hi_nxt;
  cmd_t        pend_r, pend_nxt;
  logic        pend_v_r, pend_v_nxt;

  logic        accept, hdr_now;
  cmd_t        c0, c1;
  logic        c0_v, c1_v;
  logic [7:0]  b;
  logic [31:0] bp;
  logic [31:0] sub;
  logic        side;
  logic [1:0]  chan;
  logic [16:0] total_w;

  assign hdr_now = in_data.record_start || (phase_r == P_HEADER);
  assign in_full = pend_v_r || q_full || (hdr_now && !(q_empty && back_idle));
  assign accept  = in_push && !in_full;
  assign b       = in_data.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    bpos_nxt   = bpos_r;
    roff_nxt   = roff_r;
    craw_nxt   = craw_r;
    total_nxt  = total_r;
    done_nxt   = done_r;
    ncnt_nxt   = ncnt_r;
    pred_nxt   = pred_r;
    scale_nxt  = scale_r;
    load_nxt   = load_r;
    hi_nxt     = hi_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    c0         = '0;
    c1         = '0;
    c0_v       = 1'b0;
    c1_v       = 1'b0;
    wr         = '0;
    bp         = bpos_r;
    sub        = '0;
    side       = 1'b0;
    chan       = CH_LEFT;
    total_w    = '0;
    q_push     = 1'b0;
    q_wdata    = pend_r;

    if (pend_v_r) begin
      // second sample of the previous byte
      if (!q_full) begin
        q_push     = 1'b1;
        pend_v_nxt = 1'b0;
      end
    end else if (accept) begin
      if (in_data.record_start) begin
        phase_nxt = P_HEADER;
        bp        = '0;
      end
      if (phase_nxt == P_HEADER) begin
        if (bp < 32'd4) begin
          roff_nxt = {roff_r[23:0], b};
        end else if (bp < 32'd8) begin
          craw_nxt = {craw_r[23:0], b};
        end else begin
          sub = bp - 32'd8;
          if (!sub[0]) begin
            hi_nxt = b;
          end else begin
            wr.we   = 1'b1;
            wr.addr = sub[6:1];
            wr.data = {hi_r, b};
          end
        end
        if (bp == 32'(HEADER_BYTES - 1)) begin
          bpos_nxt = '0;
          if (craw_nxt[31])
            total_w = '0;
          else if (craw_nxt > 32'(MAX_SAMPLES))
            total_w = 17'(MAX_SAMPLES);
          else
            total_w = {1'b0, craw_nxt[15:0]};
          total_nxt = total_w[15:0];
          if (total_w == '0) begin
            phase_nxt = P_IDLE;
          end else begin
            phase_nxt = P_LEFT;
            ncnt_nxt  = '0;
            done_nxt  = '0;
            load_nxt  = 1'b1;
          end
        end else begin
          bpos_nxt = bp + 32'd1;
        end
      end else if (phase_nxt != P_IDLE) begin
        if (phase_nxt == P_SKIP && bp >= roff_r) begin
          phase_nxt = P_RIGHT;
          ncnt_nxt  = '0;
          done_nxt  = '0;
          load_nxt  = 1'b1;
        end
        side = (phase_nxt == P_RIGHT);
        chan = (roff_r == '0) ? CH_BOTH : (side ? CH_RIGHT : CH_LEFT);
        if (phase_nxt == P_LEFT || phase_nxt == P_RIGHT) begin
          if (ncnt_nxt == '0) begin
            pred_nxt  = b[6:4];
            scale_nxt = b[3:0];
            ncnt_nxt  = 4'd2;
          end else begin
            c0_v         = 1'b1;
            c0.nib       = b[7:4];
            c0.side      = side;
            c0.pred      = pred_r;
            c0.scale     = scale_r;
            c0.load_hist = load_nxt;
            c0.channel   = chan;
            c0.index     = done_nxt;
            c0.last      = 1'b1;
            load_nxt     = 1'b0;
            done_nxt     = done_nxt + 16'd1;
            ncnt_nxt     = ncnt_nxt + 4'd1;
            if (done_nxt >= total_r) begin
              if (phase_nxt == P_LEFT && roff_r != '0) begin
                phase_nxt = P_SKIP;
              end else begin
                phase_nxt = P_IDLE;
                c0.done   = 1'b1;
              end
            end else begin
              c1_v       = 1'b1;
              c0.last    = 1'b0;
              c1         = c0;
              c1.nib     = b[3:0];
              c1.load_hist = 1'b0;
              c1.index   = done_nxt;
              c1.last    = 1'b1;
              done_nxt   = done_nxt + 16'd1;
              ncnt_nxt   = ncnt_nxt + 4'd1;
              if (done_nxt >= total_r) begin
                if (phase_nxt == P_LEFT && roff_r != '0) begin
                  phase_nxt = P_SKIP;
                end else begin
                  phase_nxt = P_IDLE;
                  c1.done   = 1'b1;
                end
              end
            end
          end
        end
        if (bp != 32'hFFFF_FFFF)
          bpos_nxt = bp + 32'd1;
        else
          bpos_nxt = bp;
      end
      if (c0_v) begin
        q_push  = 1'b1;
        q_wdata = c0;
      end
      if (c1_v) begin
        pend_nxt   = c1;
        pend_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= P_IDLE;
      bpos_r   <= '0;
      roff_r   <= '0;
      craw_r   <= '0;
      total_r  <= '0;
      done_r   <= '0;
      ncnt_r   <= 4'd2;
      pred_r   <= '0;
      scale_r  <= '0;
      load_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      bpos_r   <= bpos_nxt;
      roff_r   <= roff_nxt;
      craw_r   <= craw_nxt;
      total_r  <= total_nxt;
      done_r   <= done_nxt;
      ncnt_r   <= ncnt_nxt;
      pred_r   <= pred_nxt;
      scale_r  <= scale_nxt;
      load_r   <= load_nxt;
      pend_v_r <= pend_v_nxt;
    end
    hi_r   <= hi_nxt;
    pend_r <= pend_nxt;
  end
endmodule

/* hdl/adrd_back.sv */
// Back: coefficient memory, start history and the sample datapath.
// Depends on adrd_pkg.
`timescale 1ns / 1ps
module adrd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  adrd_pkg::wr_t  wr,
  input  adrd_pkg::cmd_t q_rdata,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           back_idle,
  output adrd_pkg::out_t out_data,
  output logic           out_empty,
  input  logic           out_pop
);
  import adrd_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_C1, B_M1, B_SUM, B_RND} bst_t;

  logic [15:0]        coef_mem [COEF_WORDS];
  logic [15:0]        mem_q_r;
  logic [4:0]         rd_addr;
  logic [15:0]        sh0_r, sh1_r, sh2_r, sh3_r;
  bst_t               st_r;
  cmd_t               cmd_r;
  logic signed [15:0] h1_r, h2_r;
  logic signed [31:0] p0_r, p1_r;
  logic signed [33:0] acc_r;
  out_t               out_r;
  logic               out_v_r;

  logic signed [33:0] nterm;
  logic signed [39:0] y, yr;
  logic signed [31:0] clamped;
  logic [15:0]        lowb;
  logic               rnd_fire;

  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign back_idle = (st_r == B_IDLE);
  assign out_data  = out_r;
  assign out_empty = !out_v_r;
  assign rnd_fire  = (st_r == B_RND) && (!out_v_r || out_pop);

  always_comb begin
    unique case (st_r)
      B_IDLE:  rd_addr = {q_rdata.side, q_rdata.pred, 1'b0};
      default: rd_addr = {cmd_r.side, cmd_r.pred, 1'b1};
    endcase
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr.we && !wr.addr[5])
      coef_mem[wr.addr[4:0]] <= wr.data;
    mem_q_r <= coef_mem[rd_addr];
  end

  always_comb begin
    nterm   = (34'(signed'(cmd_r.nib)) <<< cmd_r.scale) <<< 11;
    y       = 40'(acc_r) <<< 5;
    lowb    = y[15:0];
    yr      = y;
    if (lowb > 16'h8000 || (lowb == 16'h8000 && y[16]))
      yr = y + 40'sh10000;
    if (yr > 40'sd2147483647)
      clamped = 32'h7FFF_FFFF;
    else if (yr < -40'sd2147483648)
      clamped = 32'h8000_0000;
    else
      clamped = yr[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      out_v_r <= 1'b0;
      h1_r    <= '0;
      h2_r    <= '0;
    end else begin
      out_v_r <= rnd_fire || (out_v_r && !out_pop);
      unique case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_rdata;
            if (q_rdata.load_hist) begin
              h1_r <= q_rdata.side ? sh2_r : sh0_r;
              h2_r <= q_rdata.side ? sh3_r : sh1_r;
            end
            st_r <= B_C1;
          end
        end
        B_C1: begin
          p0_r <= signed'(mem_q_r) * h1_r;
          st_r <= B_M1;
        end
        B_M1: begin
          p1_r <= signed'(mem_q_r) * h2_r;
          st_r <= B_SUM;
        end
        B_SUM: begin
          acc_r <= 34'(p0_r) + 34'(p1_r) + nterm;
          st_r  <= B_RND;
        end
        B_RND: begin
          // hold until the output register is free
          if (rnd_fire) begin
            out_r.pcm_sample   <= clamped[31:16];
            out_r.channel      <= cmd_r.channel;
            out_r.sample_index <= cmd_r.index;
            out_r.last_of_item <= cmd_r.last;
            out_r.record_done  <= cmd_r.done;
            h2_r               <= h1_r;
            h1_r               <= clamped[31:16];
            st_r               <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
    if (wr.we && wr.addr[5]) begin
      case (wr.addr[1:0])
        2'd0:    sh0_r <= wr.data;
        2'd1:    sh1_r <= wr.data;
        2'd2:    sh2_r <= wr.data;
        default: sh3_r <= wr.data;
      endcase
    end
  end
endmodule

/* hdl/adrd_top_body.sv */
// Holds no design units; the top level is in adpcm_audio_record_decoder_top.sv.
// No dependencies.
`timescale 1ns / 1ps

/* tb/testbench.sv */
// Self-checking bench for adpcm_audio_record_decoder_top: records fed byte by byte,
// decoded samples predicted in the bench and compared in order.
// Depends on adrd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module testbench;
  import adrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PH_IDLE = 0, PH_HEADER = 1, PH_LEFT = 2, PH_SKIP = 3, PH_RIGHT = 4;

  typedef struct {
    bit  wait_drain;
    in_t byte_item;
  } pend_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_t  in_data = '0;
  logic in_full;
  out_t out_data;
  logic out_empty;
  logic out_pop = 1'b0;

  adpcm_audio_record_decoder_top DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_data(out_data), .out_empty(out_empty), .out_pop(out_pop)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pend_t       byte_queue[$];
  out_t        sample_queue[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned samples_seen = 0;
  int unsigned records_built = 0;
  int unsigned total_bytes = 0;
  int unsigned cycles = 0;
  bit          quiet_tail = 1'b0;

  // decoder state as the bench sees it
  logic [15:0] coef_mem[32];
  logic [15:0] hist_init[4];
  longint      hist_a, hist_b;
  int unsigned n_samples, r_offset, byte_pos, phase_now, pred_sel, scale_sh;
  int unsigned nib_cnt, n_done;
  logic [31:0] count_word;

  function automatic logic signed [15:0] decode_sample(logic [3:0] nib, int unsigned side);
    int unsigned base;
    longint c0, c1, n, yn, lo;
    base = (side * 16 + pred_sel * 2) & 31;
    c0 = longint'($signed(coef_mem[base]));
    c1 = longint'($signed(coef_mem[(base + 1) & 31]));
    n  = longint'($signed(nib));
    yn = c1 * hist_b + c0 * hist_a + n * (longint'(1) << scale_sh) * 2048;
    yn = yn * 32;
    lo = yn & 'hFFFF;
    if (lo > 'h8000) yn = yn + 'h10000;
    else if (lo == 'h8000 && ((yn >> 16) & 1) == 1) yn = yn + 'h10000;
    if (yn > 64'sd2147483647) yn = 64'sd2147483647;
    if (yn < -64'sd2147483648) yn = -64'sd2147483648;
    return yn[31:16];
  endfunction

  task automatic open_channel(int unsigned ph);
    int unsigned h;
    h = (ph == PH_RIGHT) ? 2 : 0;
    phase_now = ph;
    hist_a = longint'($signed(hist_init[h]));
    hist_b = longint'($signed(hist_init[h + 1]));
    nib_cnt = 0;
    n_done = 0;
  endtask

  task automatic predict_byte(in_t it);
    logic [7:0]  b;
    int unsigned w, side, first, k;
    logic [3:0]  nib;
    out_t        r;
    bit          fin;
    b = it.data_byte;
    first = sample_queue.size();
    k = 0;
    if (it.record_start) begin
      phase_now = PH_HEADER;
      byte_pos = 0;
    end
    if (phase_now == PH_IDLE) return;
    if (phase_now == PH_HEADER) begin
      if (byte_pos < 4) r_offset = (r_offset << 8) | 32'(b);
      else if (byte_pos < 8) count_word = (count_word << 8) | 32'(b);
      else begin
        w = (byte_pos - 8) >> 1;
        if (w < 32) begin
          if (((byte_pos - 8) & 1) == 0) coef_mem[w] = {b, 8'h00};
          else coef_mem[w][7:0] = b;
        end else begin
          if (((byte_pos - 8) & 1) == 0) hist_init[(w - 32) & 3] = {b, 8'h00};
          else hist_init[(w - 32) & 3][7:0] = b;
        end
      end
      byte_pos++;
      if (byte_pos >= HEADER_BYTES) begin
        byte_pos = 0;
        if (count_word[31]) n_samples = 0;
        else n_samples = (count_word > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : count_word;
        if (n_samples == 0) phase_now = PH_IDLE;
        else open_channel(PH_LEFT);
      end
      return;
    end
    if (phase_now == PH_SKIP && byte_pos >= r_offset) open_channel(PH_RIGHT);
    if (phase_now == PH_LEFT || phase_now == PH_RIGHT) begin
      if (nib_cnt == 0) begin
        pred_sel = 32'((b & 8'h70) >> 4);
        scale_sh = 32'(b & 8'h0f);
        nib_cnt = 2;
      end else begin
        for (int half = 0; half < 2; half++) begin
          if (n_done >= n_samples) break;
          nib  = half ? b[3:0] : b[7:4];
          side = (phase_now == PH_RIGHT) ? 1 : 0;
          r.pcm_sample = decode_sample(nib, side);
          hist_b = hist_a;
          hist_a = longint'(r.pcm_sample);
          r.channel = (r_offset == 0) ? CH_BOTH : (side ? CH_RIGHT : CH_LEFT);
          r.sample_index = n_done[15:0];
          r.last_of_item = 1'b0;
          r.record_done = 1'b0;
          n_done++;
          nib_cnt = (nib_cnt + 1) & 4'hF;
          fin = (n_done >= n_samples);
          if (fin) begin
            if (phase_now == PH_LEFT && r_offset != 0) phase_now = PH_SKIP;
            else begin
              phase_now = PH_IDLE;
              r.record_done = 1'b1;
            end
          end
          sample_queue.push_back(r);
          k++;
          if (fin) break;
        end
      end
    end
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    if (k > 0) sample_queue[first + k - 1].last_of_item = 1'b1;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %0s at result %0d: got %0h, want %0h", what, samples_seen, got, want);
  endtask

  // Driver: present queued bytes with random gaps, holding on full
  int unsigned gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** adpcm_audio_record_decoder_top: FAILED **");
      $finish;
    end
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_byte(in_data);
        bytes_sent++;
      end
      if (!(in_push && in_full)) begin
        if (gap > 0) begin
          gap--;
          in_push <= 1'b0;
        end else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].wait_drain && sample_queue.size() > 0)) begin
          in_data <= byte_queue[0].byte_item;
          byte_queue.pop_front();
          in_push <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results with random stalls and check them in order
  int unsigned stall = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (sample_queue.size() == 0) begin
          report("unexpected result", 32'(out_data.sample_index), 32'd0);
        end else begin
          if (out_data.pcm_sample !== sample_queue[0].pcm_sample)
            report("pcm_sample", 32'(out_data.pcm_sample), 32'(sample_queue[0].pcm_sample));
          if (out_data.channel !== sample_queue[0].channel)
            report("channel", 32'(out_data.channel), 32'(sample_queue[0].channel));
          if (out_data.sample_index !== sample_queue[0].sample_index)
            report("sample_index", 32'(out_data.sample_index),
                   32'(sample_queue[0].sample_index));
          if (out_data.last_of_item !== sample_queue[0].last_of_item)
            report("last_of_item", 32'(out_data.last_of_item),
                   32'(sample_queue[0].last_of_item));
          if (out_data.record_done !== sample_queue[0].record_done)
            report("record_done", 32'(out_data.record_done),
                   32'(sample_queue[0].record_done));
          sample_queue.pop_front();
        end
        samples_seen++;
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 5);
      end
    end
  end

  task automatic add_byte(logic [7:0] b, bit start, bit drain = 1'b0);
    pend_t p;
    p.wait_drain = drain;
    p.byte_item.data_byte = b;
    p.byte_item.record_start = start;
    byte_queue.push_back(p);
  endtask

  function automatic int unsigned channel_bytes(int unsigned s);
    int unsigned rem;
    rem = s % 14;
    return (s / 14) * 8 + ((rem != 0) ? 1 + (rem + 1) / 2 : 0);
  endfunction

  // Header then data_len bytes of random frame content
  task automatic add_record(logic [31:0] offs, logic [31:0] cnt, int unsigned data_len,
                            bit drain = 1'b0);
    for (int i = 0; i < 4; i++) add_byte(offs[31 - 8 * i -: 8], i == 0, drain && i == 0);
    for (int i = 0; i < 4; i++) add_byte(cnt[31 - 8 * i -: 8], 1'b0);
    for (int i = 0; i < 72; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    for (int i = 0; i < data_len; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    records_built++;
  endtask

  // Well-formed record, mono or stereo, with a few trailing bytes
  task automatic add_good_record(int unsigned s, bit stereo, bit drain = 1'b0);
    int unsigned left_len, offs, span;
    left_len = channel_bytes(s);
    offs = 0;
    span = left_len;
    if (stereo) begin
      offs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, left_len) :
             left_len + $urandom_range(0, 5);
      span = ((offs > left_len) ? offs : left_len) + channel_bytes(s);
    end
    add_record(offs, s, span + $urandom_range(0, 2), drain);
  endtask

  initial begin
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_good_record(3, 1'b0);
    add_good_record(1, 1'b1);
    add_record(32'h0000_0004, 32'h8000_0005, 2);
    add_record(32'h0000_0000, 32'h0000_0000, 2);
    // saturating count, cut short by a restart
    add_record(32'hFFFF_FFFF, 32'h7FFF_FFFF, 12);
    add_good_record(28, 1'b1, 1'b1);
    while (byte_queue.size() < 700) begin
      case ($urandom_range(0, 9))
        0: add_byte(8'($urandom_range(0, 255)), 1'b0);
        1: add_record($urandom, $urandom_range(1, 40), $urandom_range(0, 10));
        default: add_good_record($urandom_range(1, 40), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 4) == 0);
      endcase
    end
    total_bytes = byte_queue.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_queue.size() > 100) @(posedge clk);
    quiet_tail = 1'b1;
    while (byte_queue.size() > 0 || in_push) @(posedge clk);
    while (sample_queue.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    mismatches += sample_queue.size();
    $display("%0d of %0d bytes in %0d records sent, %0d samples checked, %0d mismatches",
             bytes_sent, total_bytes, records_built, samples_seen, mismatches);
    if (mismatches == 0) $display("** adpcm_audio_record_decoder_top: PASSED **");
    else $display("** adpcm_audio_record_decoder_top: FAILED **");
    $finish;
  end

endmodule
